// File: rtl/rds_pkg.sv
// shared types and constants for the reaction-diffusion stencil
`default_nettype none
package rds_pkg;

    localparam int DATA_WIDTH    = 18;
    localparam int COEF_WIDTH    = 16;
    localparam int COEF_FRAC     = 16;
    localparam int DT_WIDTH      = 17;
    localparam int SIZE_WIDTH    = 11;
    localparam int CFG_IDX_WIDTH = 3;
    localparam int CFG_WIDTH     = 17;

    localparam int DEF_MAX_COLUMNS   = 1024;
    localparam int DEF_MAX_ROWS      = 1024;
    localparam int DEF_FRACTION_BITS = 16;

    // register indexes
    localparam logic [CFG_IDX_WIDTH-1:0] REG_DIFF_U = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_DIFF_V = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_FEED   = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_KILL   = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_DT     = 3'd4;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_COLS   = 3'd5;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_ROWS   = 3'd6;

    // one 3x3 neighbourhood handed from the front to the back
    // neighbour sum is eight values wide
    typedef struct packed {
        logic signed [DATA_WIDTH+2:0] u_sum;
        logic signed [DATA_WIDTH+2:0] v_sum;
        logic signed [DATA_WIDTH-1:0] u_centre;
        logic signed [DATA_WIDTH-1:0] v_centre;
        logic                         last;
    } window_t;

endpackage
`default_nettype wire

// File: rtl/rds_ram.sv
// generic single-write, single-read ram with registered read
`default_nettype none
module rds_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// File: rtl/rds_front.sv
// front end: line stores, 3x3 window, raster position and halo classification
`default_nettype none
module rds_front #(
    parameter int MAX_COLUMNS = 1024,
    parameter int MAX_ROWS    = 1024
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic signed [rds_pkg::DATA_WIDTH-1:0] u_in,
    input  wire logic signed [rds_pkg::DATA_WIDTH-1:0] v_in,
    input  wire logic [rds_pkg::SIZE_WIDTH-1:0]        grid_columns,
    input  wire logic [rds_pkg::SIZE_WIDTH-1:0]        grid_rows,
    output logic                                       win_valid,
    input  wire logic                                  win_ready,
    output rds_pkg::window_t                           win
);

    localparam int CW = $clog2(MAX_COLUMNS);
    localparam int CCW = $clog2(MAX_COLUMNS + 1);
    localparam int RCW = $clog2(MAX_ROWS + 1);
    localparam int DW = rds_pkg::DATA_WIDTH;
    localparam int SW = rds_pkg::SIZE_WIDTH;
    localparam int XW = (CCW > SW) ? CCW : SW;
    localparam int YW = (RCW > SW) ? RCW : SW;

    // stage a: accepted item waits for line store read
    logic            a_valid_reg;
    logic [DW-1:0]   a_u_reg, a_v_reg;
    logic            a_inner_reg, a_last_reg;
    logic [CW-1:0]   col_reg;
    logic [RCW-1:0]  row_reg;
    logic [CW-1:0]   a_col_reg;

    logic [DW-1:0] ut, um, vt, vm;
    logic [DW-1:0] uw_reg [6];
    logic [DW-1:0] vw_reg [6];

    logic            win_valid_reg;
    rds_pkg::window_t win_reg;

    logic [XW-1:0] cols_c;
    logic [YW-1:0] rows_c;
    logic          last_col, last_row, adv, fire, out_free;

    // clamp the grid size to the supported range
    always_comb
    begin
        cols_c = XW'(grid_columns);
        if (grid_columns < SW'(3))
        begin
            cols_c = XW'(3);
        end
        else if (XW'(grid_columns) > XW'(MAX_COLUMNS))
        begin
            cols_c = XW'(MAX_COLUMNS);
        end
        rows_c = YW'(grid_rows);
        if (grid_rows < SW'(3))
        begin
            rows_c = YW'(3);
        end
        else if (YW'(grid_rows) > YW'(MAX_ROWS))
        begin
            rows_c = YW'(MAX_ROWS);
        end
    end

    assign last_col = XW'(col_reg) >= cols_c - XW'(1);
    assign last_row = YW'(row_reg) >= rows_c - YW'(1);

    // stage a may advance when the window output is free
    assign out_free = !win_valid_reg || win_ready;
    assign adv      = a_valid_reg && out_free;
    assign in_ready = !a_valid_reg || adv;
    assign fire     = in_valid && in_ready;

    // line store reads for the incoming column, written when it moves on
    rds_ram #(.WIDTH(2 * DW), .DEPTH(MAX_COLUMNS)) u_rows_ram (
        .clk   (clk),
        .we    (adv),
        .waddr (a_col_reg),
        .wdata ({um, a_u_reg}),
        .re    (fire),
        .raddr (col_reg),
        .rdata ({ut, um})
    );

    rds_ram #(.WIDTH(2 * DW), .DEPTH(MAX_COLUMNS)) v_rows_ram (
        .clk   (clk),
        .we    (adv),
        .waddr (a_col_reg),
        .wdata ({vm, a_v_reg}),
        .re    (fire),
        .raddr (col_reg),
        .rdata ({vt, vm})
    );

    // position counters and stage a control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            a_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                a_valid_reg <= 1'b1;
                if (last_col)
                begin
                    col_reg <= '0;
                    row_reg <= last_row ? '0 : row_reg + RCW'(1);
                end
                else
                begin
                    col_reg <= col_reg + CW'(1);
                end
            end
            else if (adv)
            begin
                a_valid_reg <= 1'b0;
            end
        end
    end

    // stage a payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            a_u_reg        <= u_in;
            a_v_reg        <= v_in;
            a_col_reg      <= col_reg;
            a_inner_reg    <= (row_reg >= RCW'(2)) && (col_reg >= CW'(2));
            a_last_reg     <= last_col && last_row;
        end
    end

    // window shift and neighbour sums
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            uw_reg[0] <= uw_reg[3];
            uw_reg[1] <= uw_reg[4];
            uw_reg[2] <= uw_reg[5];
            uw_reg[3] <= ut;
            uw_reg[4] <= um;
            uw_reg[5] <= a_u_reg;
            vw_reg[0] <= vw_reg[3];
            vw_reg[1] <= vw_reg[4];
            vw_reg[2] <= vw_reg[5];
            vw_reg[3] <= vt;
            vw_reg[4] <= vm;
            vw_reg[5] <= a_v_reg;
            win_reg.u_sum <= (DW+3)'($signed(uw_reg[0])) + (DW+3)'($signed(uw_reg[1]))
                + (DW+3)'($signed(uw_reg[2])) + (DW+3)'($signed(uw_reg[3]))
                + (DW+3)'($signed(uw_reg[5])) + (DW+3)'($signed(ut))
                + (DW+3)'($signed(um)) + (DW+3)'($signed(a_u_reg));
            win_reg.v_sum <= (DW+3)'($signed(vw_reg[0])) + (DW+3)'($signed(vw_reg[1]))
                + (DW+3)'($signed(vw_reg[2])) + (DW+3)'($signed(vw_reg[3]))
                + (DW+3)'($signed(vw_reg[5])) + (DW+3)'($signed(vt))
                + (DW+3)'($signed(vm)) + (DW+3)'($signed(a_v_reg));
            win_reg.u_centre <= uw_reg[4];
            win_reg.v_centre <= vw_reg[4];
            win_reg.last     <= a_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            win_valid_reg <= adv && a_inner_reg;
        end
    end

    assign win_valid = win_valid_reg;
    assign win       = win_reg;

`ifndef SYNTH
    a_hold : assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg && !out_free |=> a_valid_reg && $stable(a_col_reg))
        else $error("stage a lost its item under stall");
    a_wrap : assert property (@(posedge clk) disable iff (!rst_n)
        fire && last_col |=> col_reg == '0)
        else $error("column counter did not wrap");
    a_win : assert property (@(posedge clk) disable iff (!rst_n)
        win_valid_reg && !win_ready |=> win_valid_reg && $stable(win_reg))
        else $error("window changed while stalled");
`endif

endmodule
`default_nettype wire

// File: rtl/rds_back.sv
// back end: reaction and diffusion update, time step and saturation
`default_nettype none
module rds_back #(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  win_valid,
    output logic                                       win_ready,
    input  rds_pkg::window_t                           win,
    input  wire logic [rds_pkg::COEF_WIDTH-1:0]        diffusion_u,
    input  wire logic [rds_pkg::COEF_WIDTH-1:0]        diffusion_v,
    input  wire logic [rds_pkg::COEF_WIDTH-1:0]        feed,
    input  wire logic [rds_pkg::COEF_WIDTH-1:0]        kill,
    input  wire logic [rds_pkg::DT_WIDTH-1:0]          time_step,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic signed [rds_pkg::DATA_WIDTH-1:0]      u_out,
    output logic signed [rds_pkg::DATA_WIDTH-1:0]      v_out,
    output logic                                       last_cell
);

    localparam int DW  = rds_pkg::DATA_WIDTH;
    localparam int CF  = rds_pkg::COEF_FRAC;
    localparam int FB  = FRACTION_BITS;
    localparam int LW  = DW + 4;
    localparam int PW  = 64;
    // widths of the rounded terms and rates
    localparam int UVVW = 3 * DW - 2 * FB + 2;
    localparam int FUW  = ((FB > DW) ? FB : DW) + 3;
    localparam int M1W  = (UVVW > LW + 2) ? UVVW : LW + 2;
    localparam int RW   = ((M1W > FUW) ? M1W : FUW) + 2;
    localparam logic signed [PW-1:0] DMAX = PW'((64'sd1 <<< (DW - 1)) - 1);
    localparam logic signed [PW-1:0] DMIN = -PW'(64'sd1 <<< (DW - 1));

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL1, ST_MUL2, ST_SUM, ST_DT, ST_OUT
    } st_t;

    st_t state_reg, state_next;

    logic signed [DW-1:0] uc_reg, vc_reg;
    logic signed [LW-1:0] lu_reg, lv_reg;
    logic                 last_reg;
    logic signed [RW-1:0] du_reg, dv_reg, uv_reg, fu_reg, kv_reg, uvv_reg;
    logic signed [RW-1:0] ru_reg, rv_reg;
    logic signed [DW-1:0] nu_reg, nv_reg;
    logic                 capture;

    // round half up by a right shift
    function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] x,
                                                  input int s);
        logic signed [PW-1:0] y;
        y = x + (PW'(64'sd1) <<< (s - 1));
        return y >>> s;
    endfunction

    function automatic logic signed [DW-1:0] sat(input logic signed [PW-1:0] x);
        logic signed [DW-1:0] r;
        r = x[DW-1:0];
        if (x > DMAX)
        begin
            r = DMAX[DW-1:0];
        end
        else if (x < DMIN)
        begin
            r = DMIN[DW-1:0];
        end
        return r;
    endfunction

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        win_ready  = 1'b0;
        out_valid  = 1'b0;
        capture    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                win_ready = 1'b1;
                if (win_valid)
                begin
                    capture    = 1'b1;
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1: state_next = ST_MUL2;
            ST_MUL2: state_next = ST_SUM;
            ST_SUM:  state_next = ST_DT;
            ST_DT:   state_next = ST_OUT;
            ST_OUT:
            begin
                out_valid = 1'b1;
                win_ready = out_ready;
                if (out_ready)
                begin
                    if (win_valid)
                    begin
                        capture    = 1'b1;
                        state_next = ST_MUL1;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath, one multiplier rank per step
    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            uc_reg   <= win.u_centre;
            vc_reg   <= win.v_centre;
            lu_reg   <= LW'(win.u_sum) - (LW'(win.u_centre) <<< 3);
            lv_reg   <= LW'(win.v_sum) - (LW'(win.v_centre) <<< 3);
            last_reg <= win.last;
        end
        case (state_reg)
            ST_MUL1:
            begin
                du_reg <= RW'(rnd(PW'($signed({1'b0, diffusion_u})) * PW'(lu_reg), CF));
                dv_reg <= RW'(rnd(PW'($signed({1'b0, diffusion_v})) * PW'(lv_reg), CF));
                uv_reg <= RW'(rnd(PW'(uc_reg) * PW'(vc_reg), FB));
                fu_reg <= RW'(rnd(PW'($signed({1'b0, feed}))
                    * ((PW'(64'sd1) <<< FB) - PW'(uc_reg)), CF));
                kv_reg <= RW'(rnd((PW'($signed({1'b0, feed}))
                    + PW'($signed({1'b0, kill}))) * PW'(vc_reg), CF));
            end
            ST_MUL2:
            begin
                uvv_reg <= RW'(rnd(PW'(uv_reg) * PW'(vc_reg), FB));
            end
            ST_SUM:
            begin
                ru_reg <= du_reg - uvv_reg + fu_reg;
                rv_reg <= dv_reg + uvv_reg - kv_reg;
            end
            ST_DT:
            begin
                nu_reg <= sat(PW'(uc_reg)
                    + rnd(PW'(ru_reg) * PW'($signed({1'b0, time_step})), CF));
                nv_reg <= sat(PW'(vc_reg)
                    + rnd(PW'(rv_reg) * PW'($signed({1'b0, time_step})), CF));
            end
            default: ;
        endcase
    end

    assign u_out     = nu_reg;
    assign v_out     = nv_reg;
    assign last_cell = last_reg;

`ifndef SYNTH
    b_hold : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(u_out) && $stable(v_out))
        else $error("result changed while stalled");
    b_take : assert property (@(posedge clk) disable iff (!rst_n)
        capture |=> state_reg == ST_MUL1)
        else $error("captured item not started");
    b_excl : assert property (@(posedge clk) disable iff (!rst_n)
        win_ready |-> (state_reg == ST_IDLE || state_reg == ST_OUT))
        else $error("ready while busy");
`endif

endmodule
`default_nettype wire

// File: rtl/reaction_diffusion_stencil_top.sv
// top level of the gray-scott reaction-diffusion stencil
// Cells of the padded grid enter on u_in/v_in in raster order (valid/ready).
// Each interior cell gives one result on u_out/v_out/last_cell (valid/ready)
// once its lower-right neighbour has been taken; halo cells give none.
// Front: two-row line stores in ram and a 3x3 window, two register stages.
// Back: a sequencer over the multiply ranks, states MUL1, MUL2, SUM, DT, OUT.
// The back takes a new interior cell only as its last result is taken;
// halo cells pass the front at one per cycle while the back is free.
// After its lower-right neighbour is accepted, a result passes stage a, the
// window register and back states MUL1, MUL2, SUM, DT before OUT offers it.
// A one-entry window register parts front and back so each stalls alone;
// a stalled receiver holds the result and in turn back-pressures the input.
// Reset clears counters and control; line store contents are left undefined
// and all coefficient registers return to their default values. Users write
// configuration cfg_we, cfg_index, cfg_data only while idle; not enforced.
`default_nettype none
module reaction_diffusion_stencil_top #(
    parameter int MAX_COLUMNS   = rds_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS      = rds_pkg::DEF_MAX_ROWS,
    parameter int FRACTION_BITS = rds_pkg::DEF_FRACTION_BITS
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_we,
    input  wire logic [rds_pkg::CFG_IDX_WIDTH-1:0]     cfg_index,
    input  wire logic [rds_pkg::CFG_WIDTH-1:0]         cfg_data,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic signed [rds_pkg::DATA_WIDTH-1:0] u_in,
    input  wire logic signed [rds_pkg::DATA_WIDTH-1:0] v_in,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic signed [rds_pkg::DATA_WIDTH-1:0]      u_out,
    output logic signed [rds_pkg::DATA_WIDTH-1:0]      v_out,
    output logic                                       last_cell
);

    localparam int CW = rds_pkg::COEF_WIDTH;
    localparam int SW = rds_pkg::SIZE_WIDTH;

    logic [CW-1:0] du_reg, dv_reg, feed_reg, kill_reg;
    logic [rds_pkg::DT_WIDTH-1:0] dt_reg;
    logic [SW-1:0] cols_reg, rows_reg;

    logic             win_valid, win_ready;
    rds_pkg::window_t win;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            du_reg   <= CW'(6554);
            dv_reg   <= CW'(3277);
            feed_reg <= CW'(918);
            kill_reg <= CW'(3539);
            dt_reg   <= rds_pkg::DT_WIDTH'(65536);
            cols_reg <= SW'(1024);
            rows_reg <= SW'(1024);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rds_pkg::REG_DIFF_U: du_reg   <= cfg_data[CW-1:0];
                rds_pkg::REG_DIFF_V: dv_reg   <= cfg_data[CW-1:0];
                rds_pkg::REG_FEED:   feed_reg <= cfg_data[CW-1:0];
                rds_pkg::REG_KILL:   kill_reg <= cfg_data[CW-1:0];
                rds_pkg::REG_DT:     dt_reg   <= cfg_data[rds_pkg::DT_WIDTH-1:0];
                rds_pkg::REG_COLS:   cols_reg <= cfg_data[SW-1:0];
                rds_pkg::REG_ROWS:   rows_reg <= cfg_data[SW-1:0];
                default: ;
            endcase
        end
    end

    rds_front #(.MAX_COLUMNS(MAX_COLUMNS), .MAX_ROWS(MAX_ROWS)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .u_in         (u_in),
        .v_in         (v_in),
        .grid_columns (cols_reg),
        .grid_rows    (rows_reg),
        .win_valid    (win_valid),
        .win_ready    (win_ready),
        .win          (win)
    );

    rds_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .win_valid   (win_valid),
        .win_ready   (win_ready),
        .win         (win),
        .diffusion_u (du_reg),
        .diffusion_v (dv_reg),
        .feed        (feed_reg),
        .kill        (kill_reg),
        .time_step   (dt_reg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .u_out       (u_out),
        .v_out       (v_out),
        .last_cell   (last_cell)
    );

endmodule
`default_nettype wire
